FILE: rtl/tntg_pkg.sv
// ----------------------------------------------------------------------------
// tntg_pkg: shared types, constants and tables of the two-voice tone generator
// Operation and register codes, the queue item, the note frequency table and
// the functions that build the quarter-wave sine table at elaboration.
// ----------------------------------------------------------------------------
package tntg_pkg;

    // Default sizes handed to the top level
    localparam int DEF_PHASE_BITS      = 32;
    localparam int DEF_SINE_TABLE_BITS = 10;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Notes a write may store, and entries in the frequency table
    localparam int NOTE_COUNT = 108;
    localparam int ROM_NOTES  = 108;

    localparam int          SCALE_BITS  = 28;
    localparam logic [27:0] SCALE_RESET = 28'd24932236;
    localparam int          FREQ_BITS   = 21;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Rounded-up reciprocals of the series denominators (2n)(2n+1); the
    // multiply and shift give the exact floor quotient for dividends below 2^40
    localparam int           SERIES_SHIFT = 49;
    localparam logic [127:0] SERIES_RECIP [8] = '{
        ((128'd1 << SERIES_SHIFT) + 128'd5) / 128'd6,
        ((128'd1 << SERIES_SHIFT) + 128'd19) / 128'd20,
        ((128'd1 << SERIES_SHIFT) + 128'd41) / 128'd42,
        ((128'd1 << SERIES_SHIFT) + 128'd71) / 128'd72,
        ((128'd1 << SERIES_SHIFT) + 128'd109) / 128'd110,
        ((128'd1 << SERIES_SHIFT) + 128'd155) / 128'd156,
        ((128'd1 << SERIES_SHIFT) + 128'd209) / 128'd210,
        ((128'd1 << SERIES_SHIFT) + 128'd271) / 128'd272
    };

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FRAME  = 2'd1,
        OP_WRITE  = 2'd2,
        OP_READ   = 2'd3
    } tntg_op_t;

    typedef enum logic [1:0] {
        REG_DUR0  = 2'd0,
        REG_DUR1  = 2'd1,
        REG_NOTE0 = 2'd2,
        REG_NOTE1 = 2'd3
    } tntg_reg_t;

    // One classified item, as it travels from the front to the back
    typedef struct packed {
        logic                 is_sample;
        logic                 act0;
        logic                 act1;
        logic [FREQ_BITS-1:0] freq0;
        logic [FREQ_BITS-1:0] freq1;
        logic [7:0]           rd;
    } tntg_item_t;

    // Equal-tempered pitches, Q8 hertz
    localparam logic [FREQ_BITS-1:0] NOTE_FREQ [ROM_NOTES] = '{
        21'd4186, 21'd4434, 21'd4698, 21'd4979, 21'd5274, 21'd5588,
        21'd5919, 21'd6272, 21'd6646, 21'd7040, 21'd7460, 21'd7903,
        21'd8371, 21'd8870, 21'd9398, 21'd9956, 21'd10547, 21'd11174,
        21'd11840, 21'd12544, 21'd13289, 21'd14080, 21'd14917, 21'd15805,
        21'd16745, 21'd17741, 21'd18796, 21'd19912, 21'd21097, 21'd22351,
        21'd23680, 21'd25088, 21'd26580, 21'd28160, 21'd29834, 21'd31608,
        21'd33487, 21'd35479, 21'd37588, 21'd39823, 21'd42191, 21'd44700,
        21'd47360, 21'd50176, 21'd53158, 21'd56320, 21'd59668, 21'd63217,
        21'd66977, 21'd70958, 21'd75177, 21'd79649, 21'd84385, 21'd89403,
        21'd94717, 21'd100352, 21'd106317, 21'd112640, 21'd119337, 21'd126433,
        21'd133952, 21'd141919, 21'd150356, 21'd159296, 21'd168768, 21'd178806,
        21'd189437, 21'd200701, 21'd212636, 21'd225280, 21'd238676, 21'd252869,
        21'd267904, 21'd283835, 21'd300713, 21'd318595, 21'd337539, 21'd357609,
        21'd378875, 21'd401403, 21'd425272, 21'd450560, 21'd477338, 21'd505728,
        21'd535808, 21'd567654, 21'd601421, 21'd637184, 21'd675072, 21'd715213,
        21'd757734, 21'd802790, 21'd850534, 21'd901120, 21'd954701, 21'd1011456,
        21'd1071616, 21'd1135334, 21'd1202842, 21'd1274368, 21'd1350144, 21'd1430426,
        21'd1515494, 21'd1605606, 21'd1701069, 21'd1802240, 21'd1909402, 21'd2022945
    };

    // Frequency of a stored note; indexes past the table take the last entry
    function automatic logic [FREQ_BITS-1:0] note_freq(input logic [7:0] note);
        logic [6:0] idx;
        idx = (note >= 8'(ROM_NOTES)) ? 7'(ROM_NOTES - 1) : note[6:0];
        return NOTE_FREQ[idx];
    endfunction

    // sin(x), x and result in Q30, x within [0, pi/2]
    function automatic logic [63:0] series_sine(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [64:0] sum;
        logic [127:0]       wide;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed({1'b0, x});
        for (int unsigned n = 1; n <= 8; n++) begin
            wide = 128'((term * x2) >> 30) * SERIES_RECIP[n - 1];
            term = 64'(wide >> SERIES_SHIFT);
            if (n[0])
                sum = sum - $signed({1'b0, term});
            else
                sum = sum + $signed({1'b0, term});
        end
        return (sum < 0) ? 64'd0 : 64'(sum);
    endfunction

    // Quarter-wave amplitude at step k of 2^qbits steps, Q15
    function automatic logic [14:0] quarter_amp(input int unsigned k,
                                                input int unsigned qbits);
        logic [63:0] x;
        logic [63:0] a;
        x = (HALF_PI_Q30 * 64'(k)) >> qbits;
        a = (series_sine(x) * 64'd32767 + (64'd1 << 29)) >> 30;
        return (a > 64'd32767) ? 15'd32767 : a[14:0];
    endfunction

endpackage

FILE: rtl/tntg_front.sv
// ----------------------------------------------------------------------------
// tntg_front: register file and item classification
// Holds the duration and note registers, applies writes and frame ticks at
// transfer, and snapshots what the back needs into one queue item.
// ----------------------------------------------------------------------------
module tntg_front
    import tntg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [1:0] operation,
    input  logic [1:0] reg_index,
    input  logic [7:0] write_value,
    input  logic       queue_full,
    output logic       push,
    output tntg_item_t item
);

    logic [7:0] dur_reg  [2];
    logic [7:0] dur_next [2];
    logic [7:0] note_reg  [2];
    logic [7:0] note_next [2];
    tntg_op_t   op;
    tntg_reg_t  sel;
    logic [7:0] note_clamped;
    logic [7:0] rd_value;

    assign op         = tntg_op_t'(operation);
    assign sel        = tntg_reg_t'(reg_index);
    assign item_stall = queue_full;
    assign push       = item_valid && !queue_full;

    assign note_clamped = (write_value > 8'(NOTE_COUNT - 1)) ? 8'(NOTE_COUNT - 1)
                                                             : write_value;

    always_comb
    begin
        unique case (sel)
            REG_DUR0:  rd_value = dur_reg[0];
            REG_DUR1:  rd_value = dur_reg[1];
            REG_NOTE0: rd_value = note_reg[0];
            REG_NOTE1: rd_value = note_reg[1];
            default:   rd_value = '0;
        endcase
    end

    always_comb
    begin
        dur_next  = dur_reg;
        note_next = note_reg;
        unique case (op)
            OP_SAMPLE: ;
            OP_FRAME:
            begin
                for (int v = 0; v < 2; v++)
                begin
                    if (dur_reg[v] != 8'd0)
                        dur_next[v] = dur_reg[v] - 8'd1;
                end
            end
            OP_WRITE:
            begin
                unique case (sel)
                    REG_DUR0:  dur_next[0]  = write_value;
                    REG_DUR1:  dur_next[1]  = write_value;
                    REG_NOTE0: note_next[0] = note_clamped;
                    REG_NOTE1: note_next[1] = note_clamped;
                    default:   ;
                endcase
            end
            OP_READ: ;
            default: ;
        endcase
    end

    always_comb
    begin
        item.is_sample = (op == OP_SAMPLE);
        item.act0      = (dur_reg[0] != 8'd0);
        item.act1      = (dur_reg[1] != 8'd0);
        item.freq0     = note_freq(note_reg[0]);
        item.freq1     = note_freq(note_reg[1]);
        item.rd        = (op == OP_READ) ? rd_value : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg  <= '{default: '0};
            note_reg <= '{default: '0};
        end
        else if (push)
        begin
            dur_reg  <= dur_next;
            note_reg <= note_next;
        end
    end

endmodule

FILE: rtl/tntg_queue.sv
// ----------------------------------------------------------------------------
// tntg_queue: small first-in first-out queue of classified items
// Decouples the front from the back so each side stalls on its own.
// ----------------------------------------------------------------------------
module tntg_queue
    import tntg_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  tntg_item_t push_item,
    input  logic       pop,
    output tntg_item_t head,
    output logic       full,
    output logic       empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tntg_item_t      mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty queue");

endmodule

FILE: rtl/tntg_back.sv
// ----------------------------------------------------------------------------
// tntg_back: phase accumulation, sine lookup and mixing pipeline
// Four stages: phase step multiply, phase add, sine table read, mix into the
// output register. The whole pipe holds while the output is stalled.
// ----------------------------------------------------------------------------
module tntg_back
    import tntg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [SCALE_BITS-1:0] phase_scale,
    input  logic                  queue_valid,
    input  tntg_item_t            head,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic signed [15:0]    sample_value,
    output logic                  sample_active,
    output logic [7:0]            read_data
);

    localparam int QB      = SINE_TABLE_BITS - 2;
    localparam int QUARTER = 1 << QB;
    localparam int PROD_W  = FREQ_BITS + SCALE_BITS;
    localparam logic [14:0] PEAK = quarter_amp(QUARTER, QB);

    logic [14:0] quarter_rom [QUARTER];

    for (genvar i = 0; i < QUARTER; i++)
    begin : g_rom
        assign quarter_rom[i] = quarter_amp(i, QB);
    end

    logic adv;

    // stage 1
    logic                  s1_valid_reg;
    logic                  s1_sample_reg;
    logic                  s1_act_reg [2];
    logic [7:0]            s1_rd_reg;
    logic [PHASE_BITS-1:0] s1_step_reg [2];
    logic [PROD_W-1:0]     prod [2];

    // stage 2
    logic                       s2_valid_reg;
    logic                       s2_sample_reg;
    logic                       s2_act_reg [2];
    logic [7:0]                 s2_rd_reg;
    logic [SINE_TABLE_BITS-1:0] s2_idx_reg [2];
    logic [PHASE_BITS-1:0]      phase_reg  [2];
    logic [PHASE_BITS-1:0]      phase_next [2];

    // stage 3
    logic               s3_valid_reg;
    logic               s3_sample_reg;
    logic               s3_act_reg [2];
    logic [7:0]         s3_rd_reg;
    logic signed [15:0] s3_amp_reg [2];
    logic signed [15:0] amp [2];

    // output
    logic               result_valid_reg;
    logic signed [15:0] sample_value_reg;
    logic               sample_active_reg;
    logic [7:0]         read_data_reg;
    logic signed [16:0] pair_sum;
    logic signed [15:0] mix;

    assign adv = !result_valid_reg || !result_stall;
    assign pop = adv && queue_valid;

    assign prod[0] = PROD_W'(head.freq0) * PROD_W'(phase_scale);
    assign prod[1] = PROD_W'(head.freq1) * PROD_W'(phase_scale);

    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            phase_next[v] = phase_reg[v];
            if (s1_sample_reg && s1_act_reg[v])
                phase_next[v] = phase_reg[v] + s1_step_reg[v];
        end
    end

    // Fold the table index onto the quarter wave and restore the sign
    always_comb
    begin
        logic [1:0]    quad;
        logic [QB-1:0] r;
        logic [QB-1:0] k;
        logic [14:0]   mag;
        for (int v = 0; v < 2; v++)
        begin
            quad   = s2_idx_reg[v][SINE_TABLE_BITS-1 -: 2];
            r      = s2_idx_reg[v][QB-1:0];
            k      = quad[0] ? QB'(-r) : r;
            mag    = (quad[0] && (r == '0)) ? PEAK : quarter_rom[k];
            amp[v] = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
    end

    always_comb
    begin
        pair_sum = {s3_amp_reg[0][15], s3_amp_reg[0]} + {s3_amp_reg[1][15], s3_amp_reg[1]};
        if (s3_act_reg[0] && s3_act_reg[1])
            mix = pair_sum[16:1];
        else if (s3_act_reg[0])
            mix = s3_amp_reg[0];
        else if (s3_act_reg[1])
            mix = s3_amp_reg[1];
        else
            mix = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            phase_reg        <= '{default: '0};
        end
        else if (adv)
        begin
            s1_valid_reg     <= queue_valid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            result_valid_reg <= s3_valid_reg;
            if (s1_valid_reg)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sample_reg  <= head.is_sample;
            s1_act_reg[0]  <= head.act0;
            s1_act_reg[1]  <= head.act1;
            s1_rd_reg      <= head.rd;
            s1_step_reg[0] <= prod[0][16 +: PHASE_BITS];
            s1_step_reg[1] <= prod[1][16 +: PHASE_BITS];

            s2_sample_reg <= s1_sample_reg;
            s2_act_reg    <= s1_act_reg;
            s2_rd_reg     <= s1_rd_reg;
            for (int v = 0; v < 2; v++)
                s2_idx_reg[v] <= phase_next[v][PHASE_BITS-1 -: SINE_TABLE_BITS];

            s3_sample_reg <= s2_sample_reg;
            s3_act_reg    <= s2_act_reg;
            s3_rd_reg     <= s2_rd_reg;
            s3_amp_reg    <= amp;

            sample_value_reg  <= s3_sample_reg ? mix : 16'sd0;
            sample_active_reg <= s3_sample_reg && (s3_act_reg[0] || s3_act_reg[1]);
            read_data_reg     <= s3_rd_reg;
        end
    end

    assign result_valid  = result_valid_reg;
    assign sample_value  = sample_value_reg;
    assign sample_active = sample_active_reg;
    assign read_data     = read_data_reg;

    a_read_not_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (read_data_reg != 8'd0))
            |-> (!sample_active_reg && (sample_value_reg == 16'sd0)))
        else $error("read result carries sample data");

    a_phase_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !(adv && s1_valid_reg && s1_sample_reg)
            |=> ($stable(phase_reg[0]) && $stable(phase_reg[1])))
        else $error("phase moved without a sample tick");

endmodule

FILE: rtl/two_channel_note_tone_generator.sv
// ----------------------------------------------------------------------------
// two_channel_note_tone_generator: two-voice sine tone generator
// Register file front, item queue, and a phase/sine/mix pipeline back.
// ----------------------------------------------------------------------------
// Each transfer on the item channel is a sample tick, a frame tick, a
// register write or a register read, and yields exactly one result transfer,
// in order. Four byte registers hold a duration and a note index per voice;
// a nonzero duration means the voice sounds, a frame tick counts it down,
// and note writes above the top note are clamped. A sample tick advances the
// 32-bit phase of each sounding voice by note frequency times phase_scale,
// shifted right by 16, reads the sine table and returns the sample (the
// average of both voices when both sound, 0 with sample_active low when
// none does). The block takes one item every cycle unless the queue is full.
// The rate is set by the phase accumulator, one add per voice per cycle, fed
// by one 21x28 multiplier per voice. A four-entry queue behind the register
// file keeps items flowing in while the result side is stalled, until it
// fills. Write phase_scale only while the block is idle.
// ----------------------------------------------------------------------------
module two_channel_note_tone_generator
    import tntg_pkg::*;
#(
    parameter int PHASE_BITS      = DEF_PHASE_BITS,
    parameter int SINE_TABLE_BITS = DEF_SINE_TABLE_BITS,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [SCALE_BITS-1:0] cfg_wdata,
    // item channel
    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [1:0]            operation,
    input  logic [1:0]            reg_index,
    input  logic [7:0]            write_value,
    // result channel
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic signed [15:0]    sample_value,
    output logic                  sample_active,
    output logic [7:0]            read_data
);

    logic [SCALE_BITS-1:0] phase_scale_reg;
    logic                  push;
    logic                  pop;
    logic                  queue_full;
    logic                  queue_empty;
    tntg_item_t            front_item;
    tntg_item_t            head_item;

    // Hold the phase step scale; reset gives the default sample rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_scale_reg <= SCALE_RESET;
        else if (cfg_we)
            phase_scale_reg <= cfg_wdata;
    end

    // Front: apply register writes and frame ticks, classify the transfer
    tntg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .operation   (operation),
        .reg_index   (reg_index),
        .write_value (write_value),
        .queue_full  (queue_full),
        .push        (push),
        .item        (front_item)
    );

    // Queue: absorb result-side stalls, holding the front only when full
    tntg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (head_item),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    // Back: advance phases, look up the sine, mix and drive the result
    tntg_back #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .phase_scale   (phase_scale_reg),
        .queue_valid   (!queue_empty),
        .head          (head_item),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_value  (sample_value),
        .sample_active (sample_active),
        .read_data     (read_data)
    );

endmodule
